### hdl/feal_pkg.sv
// Shared types, constants and round functions for the FEAL-N cipher block.
`default_nettype none

package feal_pkg;

  // Number of round stages in the unrolled pipeline (largest supported N)
  localparam int MAX_ROUNDS = 32;
  localparam int RND_W      = $clog2(MAX_ROUNDS);
  localparam int CNT_W      = RND_W + 1;

  // Width of the round count register
  localparam int RC_W       = 6;
  localparam logic [RC_W-1:0] RC_RESET = RC_W'(8);

  // Register select: paddr bit 3 picks the register (8-byte spacing)
  localparam int    CFG_AW       = 4;
  localparam logic  REG_SEL_KEY  = 1'b0;
  localparam logic  REG_SEL_RNDS = 1'b1;

  // Item command codes
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef logic [15:0] subkey_t;
  typedef subkey_t [MAX_ROUNDS-1:0] rkey_vec_t;

  // Key schedule outputs seen by the datapath
  typedef struct packed {
    logic                  busy;
    logic [MAX_ROUNDS-1:0] stage_on;
    rkey_vec_t             enc_key;
    rkey_vec_t             dec_key;
    logic [3:0][31:0]      wk;
  } sched_t;

  // One pipeline slot: round state held as (a, b), t = a ^ f(b, k)
  typedef struct packed {
    logic        vld;
    logic        cmd;
    logic [31:0] a;
    logic [31:0] b;
  } stage_t;

  // S-box: rotate left by two of (x + y + d) mod 256
  function automatic logic [7:0] sbox(input logic [7:0] x, input logic [7:0] y,
                                      input logic d);
    logic [7:0] s;
    s = x + y + {7'b0, d};
    return {s[5:0], s[7:6]};
  endfunction

  // fk function of the key schedule (byte 0 is the MSB)
  function automatic logic [31:0] key_mix(input logic [31:0] a, input logic [31:0] b);
    logic [7:0] c0, c1, c2, c3;
    c1 = sbox(a[31:24] ^ a[23:16], a[15:8] ^ a[7:0] ^ b[31:24], 1'b1);
    c2 = sbox(a[15:8] ^ a[7:0], c1 ^ b[23:16], 1'b0);
    c0 = sbox(a[31:24], c1 ^ b[15:8], 1'b0);
    c3 = sbox(a[7:0], c2 ^ b[7:0], 1'b1);
    return {c0, c1, c2, c3};
  endfunction

  // f function of one Feistel round
  function automatic logic [31:0] mangle(input logic [31:0] x, input subkey_t k);
    logic [7:0] t1, t2;
    t1 = x[23:16] ^ k[15:8] ^ x[31:24];
    t2 = x[15:8] ^ k[7:0] ^ x[7:0];
    t1 = sbox(t1, t2, 1'b1);
    t2 = sbox(t2, t1, 1'b0);
    return {sbox(x[31:24], t1, 1'b0), t1, t2, sbox(x[7:0], t2, 1'b1)};
  endfunction

endpackage

`default_nettype wire

### hdl/feal_key_sched.sv
// Key schedule sequencer: expands the key into per-stage round keys and whitening words.
`default_nettype none

module feal_key_sched (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr,
  input  wire logic [63:0]               key,
  input  wire logic [feal_pkg::RC_W-1:0] round_count,
  output feal_pkg::sched_t               sched
);
  import feal_pkg::*;

  typedef enum logic [2:0] {
    KS_IDLE = 3'b001,
    KS_LOAD = 3'b010,
    KS_RUN  = 3'b100
  } ks_state_t;

  ks_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]      n_r;
  logic [RND_W-1:0]      iter_r;
  logic [31:0]           a_r, b_r, prev_r;
  logic [MAX_ROUNDS-1:0] stage_on_r;
  rkey_vec_t             enc_key_r, dec_key_r;
  logic [3:0][31:0]      wk_r;

  logic [CNT_W-1:0]      n_eff;
  logic [31:0]           t;
  logic [CNT_W-1:0]      sk_idx;
  logic                  is_round;
  logic [RND_W-1:0]      enc_idx, dec_idx0, dec_idx1;
  logic [1:0]            wk_idx;
  logic                  last_iter;

  // Even round count, clamped to [2, MAX_ROUNDS]
  always_comb begin
    n_eff = {round_count[RC_W-1:1], 1'b0};
    if (n_eff < CNT_W'(2)) n_eff = CNT_W'(2);
    if (n_eff > CNT_W'(MAX_ROUNDS)) n_eff = CNT_W'(MAX_ROUNDS);
  end

  // One fk evaluation per cycle gives subkeys 2i and 2i+1
  always_comb begin
    t         = key_mix(a_r, b_r ^ prev_r);
    sk_idx    = {iter_r, 1'b0};
    is_round  = sk_idx < n_r;
    // rounds run in the last N stages; decrypt walks the keys backward
    enc_idx   = RND_W'(CNT_W'(MAX_ROUNDS) - n_r + sk_idx);
    dec_idx0  = RND_W'(CNT_W'(MAX_ROUNDS - 1) - sk_idx);
    dec_idx1  = RND_W'(CNT_W'(MAX_ROUNDS - 2) - sk_idx);
    // subkey pairs past N are the whitening words, one fk output each
    wk_idx    = 2'(iter_r - n_r[CNT_W-1:1]);
    last_iter = iter_r == RND_W'(n_r[CNT_W-1:1] + RND_W'(3));
  end

  // Sequencer; a write during the load cycle loads again
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      KS_IDLE: if (cfg_wr) state_nxt = KS_LOAD;
      KS_LOAD: begin
        if (cfg_wr) state_nxt = KS_LOAD;
        else state_nxt = KS_RUN;
      end
      KS_RUN: begin
        if (cfg_wr) state_nxt = KS_LOAD;
        else if (last_iter) state_nxt = KS_IDLE;
      end
      default: state_nxt = KS_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KS_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Schedule working registers and result registers
  always_ff @(posedge clk) begin
    if (state_r == KS_LOAD) begin
      n_r    <= n_eff;
      iter_r <= '0;
      a_r    <= key[63:32];
      b_r    <= key[31:0];
      prev_r <= '0;
      for (int j = 0; j < MAX_ROUNDS; j++) begin
        stage_on_r[j] <= (CNT_W'(j) + n_eff) >= CNT_W'(MAX_ROUNDS);
      end
    end else if (state_r == KS_RUN) begin
      iter_r <= iter_r + RND_W'(1);
      prev_r <= a_r;
      a_r    <= b_r;
      b_r    <= t;
      if (is_round) begin
        enc_key_r[enc_idx]                 <= t[31:16];
        enc_key_r[enc_idx + RND_W'(1)]     <= t[15:0];
        dec_key_r[dec_idx0]                <= t[31:16];
        dec_key_r[dec_idx1]                <= t[15:0];
      end else begin
        wk_r[wk_idx] <= t;
      end
    end
  end

  assign sched.busy     = state_r != KS_IDLE;
  assign sched.stage_on = stage_on_r;
  assign sched.enc_key  = enc_key_r;
  assign sched.dec_key  = dec_key_r;
  assign sched.wk       = wk_r;

endmodule

`default_nettype wire

### hdl/feal_round.sv
// One Feistel round pipeline stage; an unused stage registers its input unchanged.
`default_nettype none

module feal_round (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              stage_on,
  input  wire feal_pkg::subkey_t enc_key,
  input  wire feal_pkg::subkey_t dec_key,
  input  wire feal_pkg::stage_t  d_in,
  output feal_pkg::stage_t       d_r
);
  import feal_pkg::*;

  subkey_t key;
  stage_t  d_nxt;

  // a' = b, b' = a ^ f(b, k)
  always_comb begin
    key   = (d_in.cmd == CMD_DECRYPT) ? dec_key : enc_key;
    d_nxt = d_in;
    if (stage_on) begin
      d_nxt.a = d_in.b;
      d_nxt.b = d_in.a ^ mangle(d_in.b, key);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r.vld <= d_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r.cmd <= d_nxt.cmd;
      d_r.a   <= d_nxt.a;
      d_r.b   <= d_nxt.b;
    end
  end

endmodule

`default_nettype wire

### hdl/feal_n_block_cipher.sv
// FEAL-N block cipher top level: configuration port, whitening, round pipeline, output.
//
// FEAL-N encryption/decryption of 64-bit blocks in ECB use. tuser selects encrypt (0) or
// decrypt (1) for each item; the left half of a block is in tdata[63:32]. The key lives at
// byte address 0 and the round count N at byte address 8 (only paddr[3] is decoded); an odd
// N uses N-1, and N is held to 2..32. The rounds are unrolled into 32 register stages that
// share one global advance, so one item enters every cycle unless the output stalls or the
// key schedule is busy; a result passes the input register, the round stages and the output
// register. A stalled output freezes the whole pipeline. After reset and every register
// write the key schedule loads and runs (N+8)/2 fk steps, one per cycle, with in_tready low.
`default_nettype none

module feal_n_block_cipher (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [63:0]                   in_tdata,   // [63:0] data_in
  input  wire logic [0:0]                    in_tuser,   // [0] command
  // result channel
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [63:0]                        out_tdata,  // [63:0] data_out
  // configuration port
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [feal_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [63:0]                   cfg_pwdata,
  output logic [63:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import feal_pkg::*;

  logic [63:0]     key_r;
  logic [RC_W-1:0] rc_r;
  logic            cfg_wr;
  sched_t          sched;

  logic            advance;
  stage_t          stage0_r;
  stage_t          pipe [MAX_ROUNDS+1];
  logic            out_tvalid_r;
  logic [63:0]     out_tdata_r;

  logic            in_cmd;
  logic [31:0]     pre_a;
  logic [31:0]     post_hi, post_lo;
  stage_t          last;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      rc_r  <= RC_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[3])
        REG_SEL_KEY:  key_r <= cfg_pwdata;
        REG_SEL_RNDS: rc_r  <= cfg_pwdata[RC_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3])
      REG_SEL_KEY:  cfg_prdata = key_r;
      REG_SEL_RNDS: cfg_prdata = {{(64-RC_W){1'b0}}, rc_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // Key schedule
  feal_key_sched u_key_sched (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr      (cfg_wr),
    .key         (key_r),
    .round_count (rc_r),
    .sched       (sched)
  );

  // Global pipeline advance
  assign advance   = !out_tvalid_r || out_tready;
  assign in_tready = advance && !sched.busy;

  // Input whitening and the left-into-right XOR
  assign in_cmd = in_tuser[0];
  assign pre_a  = in_tdata[63:32] ^ ((in_cmd == CMD_DECRYPT) ? sched.wk[2] : sched.wk[0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage0_r.vld <= 1'b0;
    end else if (advance) begin
      stage0_r.vld <= in_tvalid && in_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage0_r.cmd <= in_cmd;
      stage0_r.a   <= pre_a;
      stage0_r.b   <= in_tdata[31:0] ^ pre_a ^
                      ((in_cmd == CMD_DECRYPT) ? sched.wk[3] : sched.wk[1]);
    end
  end

  assign pipe[0] = stage0_r;

  // Round stages
  for (genvar j = 0; j < MAX_ROUNDS; j++) begin : g_round
    feal_round u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (advance),
      .stage_on (sched.stage_on[j]),
      .enc_key  (sched.enc_key[j]),
      .dec_key  (sched.dec_key[j]),
      .d_in     (pipe[j]),
      .d_r      (pipe[j+1])
    );
  end

  // Output XOR, whitening and half swap
  assign last    = pipe[MAX_ROUNDS];
  assign post_hi = last.b ^ ((last.cmd == CMD_DECRYPT) ? sched.wk[0] : sched.wk[2]);
  assign post_lo = last.a ^ last.b ^
                   ((last.cmd == CMD_DECRYPT) ? sched.wk[1] : sched.wk[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (advance) begin
      out_tvalid_r <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tdata_r <= {post_hi, post_lo};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire
